>>> hdl/linear_probe_hash_table_defines.svh
// ----------------------------------------------------------------------------
// linear_probe_hash_table_defines
// assertion macros used by the hash table rtl
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// same-cycle implication
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// constants and codes of the linear probing hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_BYTES   = 8;
    localparam int DEF_VALUE_BITS  = 64;

    localparam int HASH_MULT = 2137;
    localparam logic [3:0] MIN_LOG2 = 4'd4;
    localparam logic [3:0] MAX_LOG2 = 4'd10;
    localparam logic [3:0] RESET_LOG2 = 4'd4;
    localparam logic [2:0] RESET_QUARTERS = 3'd3;

    localparam logic CFG_CAPACITY_LOG2 = 1'b0;
    localparam logic CFG_LOAD_LIMIT    = 1'b1;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FOUND     = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_LIVE    = 2'd1,
        MARK_DELETED = 2'd2
    } mark_t;

endpackage

>>> hdl/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// open addressing hash table with linear probing and tombstones
//
// one request item in (mode, key, entry_value), one result item out.
// insert replaces a matching key, fills the first free or deleted slot or reports full,
// remove leaves a deleted mark, lookup returns the stored handle, mode 3 finds nothing.
// the home slot is hashed and its read issued at the accepting edge; the
// probe ends at a match, an empty slot or once the whole capacity is read,
// and its result is then registered. no new item is taken while a probe
// runs. the probe loop reads one slot per cycle from one ram port.
// the next item is taken once the result is registered, even while that
// result still waits on m_ready.
// a stalled receiver holds the finished probe until the output is free.
// after reset the slot marks are swept clear, with s_ready low;
// configuration writes are taken throughout.
// TABLE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_BYTES   = DEF_KEY_BYTES,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [63:0] s_key,
    input  logic [63:0] s_entry_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [63:0] m_found_value,
    output logic [9:0]  m_slot_index,
    output logic [10:0] m_live_entries,
    output logic        m_grow_needed
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int GW = AW + 4;
    localparam int KW = 8 * KEY_BYTES;
    localparam int MW = KW + VALUE_BITS + 2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic [3:0]        cap_log2_reg;
    logic [2:0]        quarters_reg;
    logic [1:0]        mode_reg;
    logic [KW-1:0]     key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CW-1:0]     cap_reg;
    logic [AW-1:0]     capmask_reg;
    logic [CW-1:0]     cnt_reg;
    logic [AW-1:0]     slot_reg;
    logic [AW-1:0]     free_reg;
    logic              have_free_reg;
    logic [CW-1:0]     live_reg;
    logic              m_valid_reg;
    logic [2:0]        m_status_reg;
    logic [63:0]       m_found_reg;
    logic [9:0]        m_slot_reg;
    logic [10:0]       m_live_reg;
    logic              m_grow_reg;

    logic              accept_c;
    logic [3:0]        lg_eff;
    logic [16:0]       pow_c;
    logic [CW-1:0]     cap_c;
    logic [AW-1:0]     capmask_c;
    logic [AW-1:0]     hash_sum;
    logic [AW-1:0]     home_c;
    logic [AW-1:0]     mult_c;
    logic [2:0]        q_eff;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [MW-1:0]     mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [MW-1:0]     mem_rdata;

    mark_t             rd_mark;
    logic [KW-1:0]     rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic              is_match;
    logic              done_c;
    logic              can_finish;
    logic              finish_c;
    logic              free_have_c;
    logic [AW-1:0]     free_slot_c;
    logic [2:0]        res_status;
    logic [AW-1:0]     res_slot;
    logic [63:0]       res_found;
    logic [CW-1:0]     live_next;
    logic              grow_c;

    assign accept_c = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);

    // capacity in use
    always_comb begin
        lg_eff = cap_log2_reg;
        if (cap_log2_reg < MIN_LOG2) begin
            lg_eff = MIN_LOG2;
        end else if (cap_log2_reg > MAX_LOG2) begin
            lg_eff = MAX_LOG2;
        end
        pow_c = 17'(1) << lg_eff;
        if (pow_c > 17'(TABLE_DEPTH)) begin
            cap_c = CW'(TABLE_DEPTH);
        end else begin
            cap_c = CW'(pow_c);
        end
        capmask_c = AW'(cap_c - CW'(1));
    end

    // home slot, only the low address bits of sum and product matter
    always_comb begin
        hash_sum = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            hash_sum = hash_sum + AW'({{16{s_key[8*b+7]}}, s_key[8*b +: 8]});
        end
        mult_c = AW'(HASH_MULT);
        home_c = AW'(hash_sum * mult_c) & capmask_c;
    end

    always_comb begin
        q_eff = quarters_reg;
        if (quarters_reg < 3'd1) begin
            q_eff = 3'd1;
        end else if (quarters_reg > 3'd4) begin
            q_eff = 3'd4;
        end
    end

    assign rd_mark = mark_t'(mem_rdata[1:0]);
    assign rd_key  = mem_rdata[2 +: KW];
    assign rd_val  = mem_rdata[2+KW +: VALUE_BITS];

    assign is_match    = (rd_mark == MARK_LIVE) && (rd_key == key_reg);
    assign done_c      = (mode_reg > MODE_LOOKUP) || (rd_mark == MARK_EMPTY) || is_match
                         || (cnt_reg == cap_reg - CW'(1));
    assign can_finish  = !m_valid_reg || m_ready;
    assign finish_c    = (state_reg == S_PROBE) && done_c && can_finish;
    assign free_have_c = have_free_reg || (rd_mark == MARK_EMPTY) || (rd_mark == MARK_DELETED);
    assign free_slot_c = have_free_reg ? free_reg : slot_reg;

    // outcome of the probe run and the write back
    always_comb begin
        res_status = ST_NOT_FOUND;
        res_slot   = '0;
        res_found  = '0;
        live_next  = live_reg;
        mem_we     = 1'b0;
        mem_waddr  = slot_reg;
        mem_wdata  = {val_reg, key_reg, MARK_LIVE};
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = {{(MW-2){1'b0}}, MARK_EMPTY};
        end else begin
            case (mode_reg)
                MODE_INSERT: begin
                    if (is_match) begin
                        res_status = ST_REPLACED;
                        res_slot   = slot_reg;
                        mem_we     = finish_c;
                    end else if (free_have_c) begin
                        res_status = ST_INSERTED;
                        res_slot   = free_slot_c;
                        live_next  = live_reg + CW'(1);
                        mem_we     = finish_c;
                        mem_waddr  = free_slot_c;
                    end else begin
                        res_status = ST_FULL;
                    end
                end
                MODE_REMOVE: begin
                    if (is_match) begin
                        res_status = ST_REMOVED;
                        res_slot   = slot_reg;
                        if (live_reg != '0) begin
                            live_next = live_reg - CW'(1);
                        end
                        mem_we    = finish_c;
                        mem_wdata = {rd_val, rd_key, MARK_DELETED};
                    end
                end
                MODE_LOOKUP: begin
                    if (is_match) begin
                        res_status = ST_FOUND;
                        res_slot   = slot_reg;
                        res_found  = 64'(rd_val);
                    end
                end
                default: begin
                    res_status = ST_NOT_FOUND;
                end
            endcase
        end
        grow_c = (GW'({live_next, 2'b00}) >= (GW'(q_eff) * GW'(cap_reg)));
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = home_c;
        if (accept_c) begin
            mem_re = 1'b1;
        end else if ((state_reg == S_PROBE) && !done_c) begin
            mem_re    = 1'b1;
            mem_raddr = (slot_reg + AW'(1)) & capmask_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            cap_log2_reg  <= RESET_LOG2;
            quarters_reg  <= RESET_QUARTERS;
            live_reg      <= '0;
            have_free_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_CAPACITY_LOG2) begin
                    cap_log2_reg <= cfg_wdata;
                end else begin
                    quarters_reg <= cfg_wdata[2:0];
                end
            end
            if (m_valid_reg && m_ready && !finish_c) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(TABLE_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept_c) begin
                        mode_reg      <= s_mode;
                        key_reg       <= s_key[KW-1:0];
                        val_reg       <= s_entry_value[VALUE_BITS-1:0];
                        cap_reg       <= cap_c;
                        capmask_reg   <= capmask_c;
                        slot_reg      <= home_c;
                        cnt_reg       <= '0;
                        have_free_reg <= 1'b0;
                        state_reg     <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (!done_c) begin
                        if (!have_free_reg && (rd_mark == MARK_DELETED)) begin
                            have_free_reg <= 1'b1;
                            free_reg      <= slot_reg;
                        end
                        slot_reg <= (slot_reg + AW'(1)) & capmask_reg;
                        cnt_reg  <= cnt_reg + CW'(1);
                    end else if (can_finish) begin
                        live_reg       <= live_next;
                        m_valid_reg    <= 1'b1;
                        m_status_reg   <= res_status;
                        m_found_reg    <= res_found;
                        m_slot_reg     <= 10'(res_slot);
                        m_live_reg     <= 11'(live_next);
                        m_grow_reg     <= grow_c;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    lpht_ram #(
        .WIDTH(MW),
        .DEPTH(TABLE_DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_found_value  = m_found_reg;
    assign m_slot_index   = m_slot_reg;
    assign m_live_entries = m_live_reg;
    assign m_grow_needed  = m_grow_reg;

    `LPHT_ASSERT_NOW(a_probe_in_range, state_reg == S_PROBE, cnt_reg < cap_reg, "probe past capacity")
    `LPHT_ASSERT_NOW(a_write_at_end, mem_we && (state_reg != S_CLEAR), finish_c, "stray slot write")
    `LPHT_ASSERT_NEXT(a_live_hold, !finish_c, live_reg == $past(live_reg), "live count moved")
    `LPHT_ASSERT_NOW(a_live_bound, 1'b1, live_reg <= CW'(TABLE_DEPTH), "live count overflow")

endmodule
